// ----- design/naive_audio_oscillator_defines.svh -----
// Assertion helpers for the oscillator modules; nao_core is the module that includes them.
// Both expect clk and rst_n to be visible where they are used.
`ifndef NAIVE_AUDIO_OSCILLATOR_DEFINES_SVH
`define NAIVE_AUDIO_OSCILLATOR_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define NAO_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that holds in the cycle after a trigger.
`define NAO_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- design/nao_pkg.sv -----
package nao_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int SampleW  = 16;
  localparam int AmpW     = 17;
  localparam int StepW    = 29;
  localparam int PeriodW  = 32;
  localparam int WidthW   = 16;
  localparam int LevelW   = 32;
  localparam int CountW   = 34;
  localparam int CalcW    = 35;
  localparam int MixW     = 19;

  typedef enum logic [1:0] {
    WAVE_SAW   = 2'd0,
    WAVE_TRI   = 2'd1,
    WAVE_PULSE = 2'd2
  } wave_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_SELECT   = 3'd0,
    REG_AMPLITUDE     = 3'd1,
    REG_RAMP_STEP     = 3'd2,
    REG_PERIOD_LENGTH = 3'd3,
    REG_PULSE_WIDTH   = 3'd4
  } cfg_reg_t;

  localparam logic signed [AmpW-1:0] AMP_ONE     = 17'sd32768;
  localparam logic signed [AmpW-1:0] AMP_NEG_ONE = -17'sd32768;
  localparam logic [StepW-1:0]       STEP_MAX    = 29'd268435456;

  localparam logic signed [CalcW-1:0] LVL_ONE   = 35'sd268435456;
  localparam logic signed [CalcW-1:0] LVL_TWO   = 35'sd536870912;
  localparam logic signed [CalcW-1:0] CNT_ONE   = 35'sd65536;
  localparam logic signed [CalcW-1:0] CNT_FLOOR = -35'sd8589934592;

  localparam logic signed [MixW-1:0] SAT_MAX = 19'sd32767;
  localparam logic signed [MixW-1:0] SAT_MIN = -19'sd32768;

  typedef struct packed {
    logic [1:0]              wave;
    logic signed [AmpW-1:0]  amplitude;
    logic [StepW-1:0]        ramp_step;
    logic [PeriodW-1:0]      len0;
    logic [PeriodW-1:0]      len1;
    logic                    ramp_wr;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic                      repl;
    logic [1:0]                wave;
    logic signed [LevelW-1:0]  level;
    logic signed [AmpW-1:0]    amp;
    logic                      negative;
  } item_t;

endpackage

// ----- design/nao_ifs.sv -----
interface nao_in_if import nao_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] in_sample;
  logic                      replace;

  modport source (output valid, in_sample, replace, input ready);
  modport sink (input valid, in_sample, replace, output ready);
endinterface

interface nao_out_if import nao_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

// ----- design/nao_cfg.sv -----
module nao_cfg import nao_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  logic [1:0]             wave_r;
  logic signed [AmpW-1:0] amp_r;
  logic [StepW-1:0]       step_r;
  logic [PeriodW-1:0]     period_r;
  logic [WidthW-1:0]      pw_r;
  logic [PeriodW-1:0]     len0_r;
  logic [PeriodW-1:0]     len1_r;

  logic signed [AmpW-1:0] amp_raw;
  logic signed [AmpW-1:0] amp_clamped;
  logic [StepW-1:0]       step_raw;
  logic [StepW-1:0]       step_clamped;
  logic [PeriodW-1:0]     period_src;
  logic [WidthW-1:0]      pw_src;
  logic [AmpW-1:0]        num0;
  logic [AmpW-1:0]        num1;
  logic [48:0]            prod0;
  logic [48:0]            prod1;
  logic [PeriodW-1:0]     len0_nxt;
  logic [PeriodW-1:0]     len1_nxt;

  always_comb begin
    amp_raw = signed'(cfg_data[AmpW-1:0]);
    if (amp_raw > AMP_ONE) begin
      amp_clamped = AMP_ONE;
    end else if (amp_raw < AMP_NEG_ONE) begin
      amp_clamped = AMP_NEG_ONE;
    end else begin
      amp_clamped = amp_raw;
    end
    step_raw     = cfg_data[StepW-1:0];
    step_clamped = (step_raw > STEP_MAX) ? STEP_MAX : step_raw;
  end

  // Half lengths of the pulse: period scaled by (1 + width) / 4 and (1 - width) / 4.
  always_comb begin
    period_src = (cfg_we && (cfg_index == REG_PERIOD_LENGTH)) ? cfg_data[PeriodW-1:0]
                                                               : period_r;
    pw_src     = (cfg_we && (cfg_index == REG_PULSE_WIDTH)) ? cfg_data[WidthW-1:0] : pw_r;
    num0       = {1'b0, ~pw_src[WidthW-1], pw_src[WidthW-2:0]};
    num1       = 17'h10000 - num0;
    prod0      = 49'(period_src) * 49'(num0);
    prod1      = 49'(period_src) * 49'(num1);
    len0_nxt   = prod0[48:17];
    len1_nxt   = prod1[48:17];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r   <= WAVE_SAW;
      amp_r    <= AMP_ONE;
      step_r   <= '0;
      period_r <= '0;
      pw_r     <= '0;
      len0_r   <= '0;
      len1_r   <= '0;
    end else begin
      len0_r <= len0_nxt;
      len1_r <= len1_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WAVE_SELECT:   wave_r   <= cfg_data[1:0];
          REG_AMPLITUDE:     amp_r    <= amp_clamped;
          REG_RAMP_STEP:     step_r   <= step_clamped;
          REG_PERIOD_LENGTH: period_r <= cfg_data[PeriodW-1:0];
          REG_PULSE_WIDTH:   pw_r     <= cfg_data[WidthW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.wave      = wave_r;
    cfg.amplitude = amp_r;
    cfg.ramp_step = step_r;
    cfg.len0      = len0_r;
    cfg.len1      = len1_r;
    cfg.ramp_wr   = cfg_we && (cfg_index == REG_RAMP_STEP);
  end

endmodule

// ----- design/nao_core.sv -----
`include "naive_audio_oscillator_defines.svh"

module nao_core import nao_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  input  logic signed [SampleW-1:0] in_sample,
  input  logic                      replace,
  input  logic                      s1_ready,
  output logic                      in_ready,
  output logic                      s1_valid,
  output item_t                     s1
);

  logic signed [LevelW-1:0] level_r, level_nxt;
  logic                     falling_r, falling_nxt;
  logic signed [CountW-1:0] hc_r, hc_nxt;
  logic                     phase_r, phase_nxt;
  logic                     neg_r, neg_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  item_t                    s1_r;

  logic                    accept;
  logic signed [CalcW-1:0] lv, st, saw_sum, tri_sum, tri_lv;
  logic signed [CalcW-1:0] h_dec, h_cl, h_len;
  logic                    tri_flip, hit;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lv      = CalcW'(level_r);
    st      = signed'(CalcW'(cfg.ramp_step));
    saw_sum = lv + st;
    tri_sum = falling_r ? (lv - (st <<< 1)) : (lv + (st <<< 1));
    if (tri_sum > LVL_ONE) begin
      tri_lv   = LVL_TWO - tri_sum;
      tri_flip = 1'b1;
    end else if (tri_sum < -LVL_ONE) begin
      tri_lv   = -LVL_TWO - tri_sum;
      tri_flip = 1'b1;
    end else begin
      tri_lv   = tri_sum;
      tri_flip = 1'b0;
    end
    h_dec = CalcW'(hc_r) - CNT_ONE;
    h_cl  = (h_dec < CNT_FLOOR) ? CNT_FLOOR : h_dec;
    hit   = (h_cl <= 0);
    // The new phase is the opposite one, so its half length is picked here.
    h_len = signed'(CalcW'(phase_r ? cfg.len0 : cfg.len1));
  end

  always_comb begin
    level_nxt   = level_r;
    falling_nxt = falling_r;
    hc_nxt      = hc_r;
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    if (accept) begin
      case (cfg.wave)
        WAVE_SAW: begin
          level_nxt = LevelW'((saw_sum > LVL_ONE) ? (saw_sum - LVL_TWO) : saw_sum);
        end
        WAVE_TRI: begin
          level_nxt   = LevelW'(tri_lv);
          falling_nxt = falling_r ^ tri_flip;
        end
        WAVE_PULSE: begin
          hc_nxt    = CountW'(hit ? (h_cl + h_len) : h_cl);
          phase_nxt = phase_r ^ hit;
          neg_nxt   = neg_r ^ hit;
        end
        default: ;
      endcase
    end
    if (cfg.ramp_wr) begin
      falling_nxt = 1'b0;
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      falling_r  <= 1'b0;
      hc_r       <= '0;
      phase_r    <= 1'b0;
      neg_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      level_r    <= level_nxt;
      falling_r  <= falling_nxt;
      hc_r       <= hc_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // The sample is formed from the state as it stood before this transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.x        <= in_sample;
      s1_r.repl     <= replace;
      s1_r.wave     <= cfg.wave;
      s1_r.level    <= level_r;
      s1_r.amp      <= cfg.amplitude;
      s1_r.negative <= neg_r;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  `NAO_ASSERT_NOW(a_level_range, (level_r >= -32'sd268435456) && (level_r <= 32'sd268435456), "level left the range of plus or minus one")
  `NAO_ASSERT_NOW(a_sign_tracks_phase, phase_r == neg_r, "pulse sign and phase disagree")
  `NAO_ASSERT_NEXT(a_idle_holds, !accept, $stable(level_r) && $stable(hc_r), "oscillator state moved without a transfer")
  `NAO_ASSERT_NEXT(a_accept_fills, accept, s1_valid_r, "accepted item did not reach the input register")

endmodule

// ----- design/nao_mix.sv -----
module nao_mix import nao_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  item_t                     s1,
  input  logic                      out_ready,
  output logic                      s1_ready,
  output logic                      out_valid,
  output logic signed [SampleW-1:0] out_sample
);

  logic                      out_valid_r;
  logic signed [SampleW-1:0] out_sample_r, out_sample_nxt;

  logic signed [48:0]      prod;
  logic signed [48:0]      scaled;
  logic signed [MixW-1:0]  amp_ext, osc, base, sum;

  always_comb begin
    prod    = 49'(s1.level) * 49'(s1.amp);
    scaled  = prod >>> 28;
    amp_ext = MixW'(s1.amp);
    case (s1.wave) inside
      WAVE_SAW, WAVE_TRI: osc = scaled[MixW-1:0];
      WAVE_PULSE:         osc = s1.negative ? -amp_ext : amp_ext;
      default:            osc = '0;
    endcase
    base = s1.repl ? '0 : MixW'(s1.x);
    sum  = base + osc;
    if (sum > SAT_MAX) begin
      out_sample_nxt = SampleW'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      out_sample_nxt = SampleW'(SAT_MIN);
    end else begin
      out_sample_nxt = sum[SampleW-1:0];
    end
  end

  assign s1_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid && s1_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// ----- design/naive_audio_oscillator.sv -----
// Sawtooth, triangle and pulse oscillator that runs at one sample per clock unless out_ch stalls.
// Each transfer on in_ch is one sample tick: the oscillator sample is formed from the current
// state, scaled by the amplitude, optionally added to the incoming sample, saturated to 16 bits
// and returned on out_ch through the s1 and mix output registers, while the waveform state
// advances in the same cycle as the transfer. A new sample is taken every cycle as long as the
// result side keeps draining. Registers written through the cfg_ port apply from the next transfer
// on; the user must write them only while no sample is in flight; the block does not enforce it.
module naive_audio_oscillator import nao_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  nao_in_if.sink              in_ch,
  nao_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t  cfg;
  item_t s1;
  logic  s1_valid;
  logic  s1_ready;

  nao_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nao_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.in_sample),
    .replace   (in_ch.replace),
    .s1_ready  (s1_ready),
    .in_ready  (in_ch.ready),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  nao_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .out_ready  (out_ch.ready),
    .s1_ready   (s1_ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.out_sample)
  );

endmodule
